>>> rtl/matrix_keypad_debounce_scanner_defines.svh
// Assertion macros for the keypad scanner RTL.
`ifndef MATRIX_KEYPAD_DEBOUNCE_SCANNER_DEFINES_SVH
`define MATRIX_KEYPAD_DEBOUNCE_SCANNER_DEFINES_SVH

`ifndef ASSERT_OFF
// Same-cycle implication, sampled on i_clk, off during reset.
`define MKDS_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);
// Next-cycle implication.
`define MKDS_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define MKDS_ASSERT_NOW(lbl, ante, cons, msg)
`define MKDS_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

>>> rtl/mkds_pkg.sv
// Shared types and constants for the keypad scanner.
package mkds_pkg;

    localparam int LEVELS_W   = 5;
    localparam int LINE_OUT_W = 2;
    localparam int KEY_OUT_W  = 5;
    localparam int MAP_W      = 20;
    localparam int LIMIT_W    = 8;

    localparam logic [LIMIT_W-1:0] LIMIT_RESET = 8'd1;

    // Register index decoded from the APB address.
    localparam logic REG_DEBOUNCE_LIMIT = 1'b0;

    typedef enum logic [1:0] {
        PHASE_IDLE     = 2'd0,
        PHASE_PRESSED  = 2'd1,
        PHASE_RELEASED = 2'd2
    } t_phase;

    localparam logic KIND_PRESS   = 1'b0;
    localparam logic KIND_RELEASE = 1'b1;

    // What one lane found for the active key of its return line.
    typedef struct packed {
        logic hit;
        logic kind;
    } t_lane_evt;

endpackage

>>> rtl/mkds_lane.sv
// One return-line lane: debounce and key machine for that column's keys.
module mkds_lane
    import mkds_pkg::*;
#(
    parameter int SCAN_LINES = 4
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_take,
    input  logic [((SCAN_LINES > 1) ? $clog2(SCAN_LINES) : 1)-1:0] i_line,
    input  logic [LIMIT_W-1:0]    i_limit,
    input  logic                  i_level,
    output t_lane_evt             o_evt,
    output logic [SCAN_LINES-1:0] o_pressed
);

    t_phase             r_phase [SCAN_LINES];
    logic               r_deb   [SCAN_LINES];
    logic [LIMIT_W-1:0] r_cnt   [SCAN_LINES];

    t_phase             n_phase;
    logic               n_deb;
    logic [LIMIT_W-1:0] n_cnt;

    t_phase             cur_phase;
    logic               cur_deb;
    logic [LIMIT_W-1:0] cur_cnt;
    logic               raw_closed;

    assign cur_phase  = r_phase[i_line];
    assign cur_deb    = r_deb[i_line];
    assign cur_cnt    = r_cnt[i_line];
    assign raw_closed = ~i_level;

    always_comb begin
        n_deb = cur_deb;
        n_cnt = '0;
        if (raw_closed != cur_deb) begin
            // a lowered limit below a running count flips on the next differing scan
            if (cur_cnt >= i_limit) begin
                n_deb = raw_closed;
            end else begin
                n_cnt = cur_cnt + 1'b1;
            end
        end

        n_phase    = cur_phase;
        o_evt.hit  = 1'b0;
        o_evt.kind = KIND_PRESS;
        unique case (cur_phase)
            PHASE_IDLE: begin
                if (n_deb) begin
                    n_phase   = PHASE_PRESSED;
                    o_evt.hit = 1'b1;
                end
            end
            PHASE_PRESSED: begin
                if (!n_deb) begin
                    n_phase    = PHASE_RELEASED;
                    o_evt.hit  = 1'b1;
                    o_evt.kind = KIND_RELEASE;
                end
            end
            default: begin
                n_phase = PHASE_IDLE;
            end
        endcase
    end

    // Map as it stands after this tick's update.
    always_comb begin
        for (int s = 0; s < SCAN_LINES; s++) begin
            if (s == int'(i_line)) begin
                o_pressed[s] = (n_phase == PHASE_PRESSED);
            end else begin
                o_pressed[s] = (r_phase[s] == PHASE_PRESSED);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int s = 0; s < SCAN_LINES; s++) begin
                r_phase[s] <= PHASE_IDLE;
                r_deb[s]   <= 1'b0;
                r_cnt[s]   <= '0;
            end
        end else if (i_take) begin
            r_phase[i_line] <= n_phase;
            r_deb[i_line]   <= n_deb;
            r_cnt[i_line]   <= n_cnt;
        end
    end

endmodule

>>> rtl/mkds_merge.sv
// Merge stage: holds one tick's lane events and emits them one per cycle while i_stall is low.
`include "matrix_keypad_debounce_scanner_defines.svh"
module mkds_merge
    import mkds_pkg::*;
#(
    parameter int SCAN_LINES   = 4,
    parameter int RETURN_LINES = 5
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_stall,
    output logic                          o_take,
    input  t_lane_evt [RETURN_LINES-1:0]  i_evt,
    input  logic [((SCAN_LINES > 1) ? $clog2(SCAN_LINES) : 1)-1:0] i_line,
    input  logic [((SCAN_LINES > 1) ? $clog2(SCAN_LINES) : 1)-1:0] i_next_line,
    input  logic [MAP_W-1:0]              i_map,
    output logic                          o_valid,
    input  logic                          i_stall,
    output logic [LINE_OUT_W-1:0]         o_next_scan_line,
    output logic                          o_event_valid,
    output logic [KEY_OUT_W-1:0]          o_event_key,
    output logic                          o_event_kind,
    output logic [MAP_W-1:0]              o_pressed_map,
    output logic                          o_last_result
);

    localparam int SW       = (SCAN_LINES > 1) ? $clog2(SCAN_LINES) : 1;
    localparam int RW       = (RETURN_LINES > 1) ? $clog2(RETURN_LINES) : 1;
    localparam int NUM_KEYS = SCAN_LINES * RETURN_LINES;
    localparam int KW       = (NUM_KEYS > 1) ? $clog2(NUM_KEYS) : 1;

    logic                    r_valid;
    logic [RETURN_LINES-1:0] r_pend;
    logic [RETURN_LINES-1:0] r_kind;
    logic [SW-1:0]           r_line;
    logic [SW-1:0]           r_next;
    logic [MAP_W-1:0]        r_map;

    logic                    n_valid;
    logic [RETURN_LINES-1:0] n_pend;

    logic [RW-1:0]           idx;
    logic [RETURN_LINES-1:0] rest;
    logic                    last;
    logic                    out_take;
    logic [KW-1:0]           key;
    logic [RETURN_LINES-1:0] evt_hit;
    logic [RETURN_LINES-1:0] evt_kind;

    always_comb begin
        for (int r = 0; r < RETURN_LINES; r++) begin
            evt_hit[r]  = i_evt[r].hit;
            evt_kind[r] = i_evt[r].kind;
        end
    end

    // lowest pending return line goes first
    always_comb begin
        idx = '0;
        for (int r = RETURN_LINES - 1; r >= 0; r--) begin
            if (r_pend[r]) begin
                idx = RW'(r);
            end
        end
    end

    assign rest     = r_pend & (r_pend - 1'b1);
    assign last     = (rest == '0);
    assign out_take = r_valid && !i_stall;
    assign o_stall  = r_valid && !(out_take && last);
    assign o_take   = i_valid && !o_stall;

    assign key = KW'(KW'(r_line) * KW'(RETURN_LINES) + KW'(idx));

    always_comb begin
        n_valid = r_valid;
        n_pend  = r_pend;
        if (o_take) begin
            n_valid = 1'b1;
            n_pend  = evt_hit;
        end else if (out_take) begin
            if (last) begin
                n_valid = 1'b0;
            end else begin
                n_pend = rest;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_pend  <= '0;
        end else begin
            r_valid <= n_valid;
            r_pend  <= n_pend;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_take) begin
            r_kind <= evt_kind;
            r_line <= i_line;
            r_next <= i_next_line;
            r_map  <= i_map;
        end
    end

    assign o_valid          = r_valid;
    assign o_next_scan_line = LINE_OUT_W'(r_next);
    assign o_event_valid    = (r_pend != '0);
    assign o_event_key      = o_event_valid ? KEY_OUT_W'(key) : '0;
    assign o_event_kind     = o_event_valid ? r_kind[idx] : KIND_PRESS;
    assign o_pressed_map    = r_map;
    assign o_last_result    = last;

    `MKDS_ASSERT_NEXT(a_take_shows_result, o_take, r_valid, "accepted tick produced no result")
    `MKDS_ASSERT_NOW(a_stall_only_when_full, o_stall, r_valid, "input stalled with empty buffer")
    `MKDS_ASSERT_NOW(a_empty_is_last, r_valid && !o_event_valid, o_last_result, "empty result not last")
    `MKDS_ASSERT_NEXT(a_more_follow, out_take && !last, r_valid && (r_pend != '0), "event lost in burst")

endmodule

>>> rtl/matrix_keypad_debounce_scanner.sv
// Top level: keypad scan lanes, merge stage and debounce-limit register.
//
//   channel   direction  handshake              payload
//   input     in         i_valid / o_stall      i_return_levels
//   output    out        o_valid / i_stall      o_next_scan_line .. o_last_result
//   config    in         APB psel/penable       paddr, pwdata, prdata
//
// When an item is taken, all lanes update their key in that cycle.
// Results appear the next cycle, one per event (one empty result if none), and
// the merge stage's one-result-per-cycle output, held while i_stall is high,
// sets the rate. A new item is taken as the last result leaves. Synchronous
// reset clears all key state at once, no sweep.
module matrix_keypad_debounce_scanner
    import mkds_pkg::*;
#(
    parameter int SCAN_LINES   = 4,
    parameter int RETURN_LINES = 5
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_stall,
    input  logic [LEVELS_W-1:0]   i_return_levels,
    output logic                  o_valid,
    input  logic                  i_stall,
    output logic [LINE_OUT_W-1:0] o_next_scan_line,
    output logic                  o_event_valid,
    output logic [KEY_OUT_W-1:0]  o_event_key,
    output logic                  o_event_kind,
    output logic [MAP_W-1:0]      o_pressed_map,
    output logic                  o_last_result,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [2:0]            paddr,
    input  logic [31:0]           pwdata,
    output logic [31:0]           prdata,
    output logic                  pready
);

    localparam int SW       = (SCAN_LINES > 1) ? $clog2(SCAN_LINES) : 1;
    localparam int NUM_KEYS = SCAN_LINES * RETURN_LINES;

    logic [LIMIT_W-1:0] r_limit;
    logic [SW-1:0]      r_scan_line;
    logic [SW-1:0]      next_line;
    logic               take;
    logic               cfg_wr;

    t_lane_evt [RETURN_LINES-1:0] lane_evt;
    logic [SCAN_LINES-1:0]        lane_pressed [RETURN_LINES];
    logic [NUM_KEYS-1:0]          pressed_all;
    logic [MAP_W-1:0]             map;

    // configuration
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;
    assign prdata = (paddr[2] == REG_DEBOUNCE_LIMIT) ? {24'd0, r_limit} : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limit <= LIMIT_RESET;
        end else if (cfg_wr && (paddr[2] == REG_DEBOUNCE_LIMIT)) begin
            r_limit <= (pwdata[LIMIT_W-1:0] == '0) ? LIMIT_RESET : pwdata[LIMIT_W-1:0];
        end
    end

    // scan line counter
    assign next_line = (r_scan_line == SW'(SCAN_LINES - 1)) ? '0 : r_scan_line + 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scan_line <= '0;
        end else if (take) begin
            r_scan_line <= next_line;
        end
    end

    for (genvar r = 0; r < RETURN_LINES; r++) begin : g_lane
        logic level;
        // return lines past the input width read low, i.e. closed
        if (r < LEVELS_W) begin : g_in
            assign level = i_return_levels[r];
        end else begin : g_pad
            assign level = 1'b0;
        end

        mkds_lane #(
            .SCAN_LINES(SCAN_LINES)
        ) u_lane (
            .i_clk     (i_clk),
            .i_rst_n   (i_rst_n),
            .i_take    (take),
            .i_line    (r_scan_line),
            .i_limit   (r_limit),
            .i_level   (level),
            .o_evt     (lane_evt[r]),
            .o_pressed (lane_pressed[r])
        );

        for (genvar s = 0; s < SCAN_LINES; s++) begin : g_key
            assign pressed_all[s * RETURN_LINES + r] = lane_pressed[r][s];
        end
    end

    for (genvar k = 0; k < MAP_W; k++) begin : g_map
        if (k < NUM_KEYS) begin : g_key
            assign map[k] = pressed_all[k];
        end else begin : g_none
            assign map[k] = 1'b0;
        end
    end

    mkds_merge #(
        .SCAN_LINES  (SCAN_LINES),
        .RETURN_LINES(RETURN_LINES)
    ) u_merge (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_stall         (o_stall),
        .o_take          (take),
        .i_evt           (lane_evt),
        .i_line          (r_scan_line),
        .i_next_line     (next_line),
        .i_map           (map),
        .o_valid         (o_valid),
        .i_stall         (i_stall),
        .o_next_scan_line(o_next_scan_line),
        .o_event_valid   (o_event_valid),
        .o_event_key     (o_event_key),
        .o_event_kind    (o_event_kind),
        .o_pressed_map   (o_pressed_map),
        .o_last_result   (o_last_result)
    );

endmodule

>>> tb/matrix_keypad_debounce_scanner_test.sv
// Self-checking testbench for the keypad scanner: scan-tick stimulus, key predictor, result check.
`timescale 1ns / 100ps

module matrix_keypad_debounce_scanner_test
    import mkds_pkg::*;
();

    localparam int NUM_LINES   = 4;
    localparam int NUM_RETURNS = 5;
    localparam int NUM_KEYS    = NUM_LINES * NUM_RETURNS;
    localparam int CYCLE_LIMIT = 200000;
    localparam int HOLD_CYCLES = 150;
    localparam logic [2:0] ADDR_LIMIT = 3'(4 * int'(REG_DEBOUNCE_LIMIT));

    typedef struct packed {
        logic [LINE_OUT_W-1:0] next_line;
        logic                  has_event;
        logic [KEY_OUT_W-1:0]  key;
        logic                  kind;
        logic [MAP_W-1:0]      map;
        logic                  last;
    } t_key_report;

    typedef struct packed {
        logic [LEVELS_W-1:0] levels;
        logic                typed;
        t_key_report         want;
    } t_script_row;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_valid = 1'b0;
    logic                  o_stall;
    logic [LEVELS_W-1:0]   i_return_levels = '1;
    logic                  o_valid;
    logic                  i_stall = 1'b0;
    logic [LINE_OUT_W-1:0] o_next_scan_line;
    logic                  o_event_valid;
    logic [KEY_OUT_W-1:0]  o_event_key;
    logic                  o_event_kind;
    logic [MAP_W-1:0]      o_pressed_map;
    logic                  o_last_result;
    logic                  psel = 1'b0;
    logic                  penable = 1'b0;
    logic                  pwrite = 1'b0;
    logic [2:0]            paddr = '0;
    logic [31:0]           pwdata = '0;
    logic [31:0]           prdata;
    logic                  pready;

    matrix_keypad_debounce_scanner dut (.*);

    always begin
        i_clk = 1'b1;
        #2;
        i_clk = 1'b0;
        #2;
    end

    // Predicted keypad state
    logic [LIMIT_W-1:0]    flip_limit = LIMIT_RESET;
    logic [LINE_OUT_W-1:0] cur_line = '0;
    t_phase                key_state [NUM_KEYS];
    logic                  deb_closed [NUM_KEYS];
    logic [LIMIT_W-1:0]    deb_count [NUM_KEYS];

    t_key_report tick_reports [$];
    t_key_report expected_reports [$];
    t_script_row pinned_rows [$];
    t_script_row script [23];

    int mismatches = 0;
    int cycle_count = 0;

    // Sender state
    logic [LINE_OUT_W-1:0] tx_line = '0;
    logic [LEVELS_W-1:0]   held_levels [NUM_LINES];
    int                    burst_left = 0;
    bit                    steady = 1'b0;

    // Receiver state
    int   holds_asked = 0;
    int   holds_served = 0;
    int   hold_left = 0;
    int   rx_mode = 0;
    logic [31:0] rx_cycle = '0;

    initial begin
        for (int k = 0; k < NUM_KEYS; k++) begin
            key_state[k]  = PHASE_IDLE;
            deb_closed[k] = 1'b0;
            deb_count[k]  = '0;
        end
        for (int l = 0; l < NUM_LINES; l++) held_levels[l] = '1;
    end

    // One scan tick: debounce and key machines for the active line, then the reports.
    function automatic void scan_tick(input logic [LEVELS_W-1:0] lv);
        logic [KEY_OUT_W-1:0] ev_key [NUM_RETURNS];
        logic                 ev_kind [NUM_RETURNS];
        int                   nev;
        int                   idx;
        logic                 raw_closed;
        logic [MAP_W-1:0]     map;
        t_key_report          rep;
        nev = 0;
        tick_reports.delete();
        for (int r = 0; r < NUM_RETURNS; r++) begin
            idx = int'(cur_line) * NUM_RETURNS + r;
            raw_closed = ~lv[r];
            if (raw_closed != deb_closed[idx]) begin
                // a count already past a lowered limit flips at once
                if (deb_count[idx] >= flip_limit) begin
                    deb_closed[idx] = raw_closed;
                    deb_count[idx]  = '0;
                end else begin
                    deb_count[idx] = deb_count[idx] + 1'b1;
                end
            end else begin
                deb_count[idx] = '0;
            end
            case (key_state[idx])
                PHASE_IDLE: begin
                    if (deb_closed[idx]) begin
                        key_state[idx] = PHASE_PRESSED;
                        ev_key[nev]  = KEY_OUT_W'(idx);
                        ev_kind[nev] = KIND_PRESS;
                        nev++;
                    end
                end
                PHASE_PRESSED: begin
                    if (!deb_closed[idx]) begin
                        key_state[idx] = PHASE_RELEASED;
                        ev_key[nev]  = KEY_OUT_W'(idx);
                        ev_kind[nev] = KIND_RELEASE;
                        nev++;
                    end
                end
                default: key_state[idx] = PHASE_IDLE;
            endcase
        end
        cur_line = LINE_OUT_W'((int'(cur_line) + 1) % NUM_LINES);
        map = '0;
        for (int k = 0; k < NUM_KEYS && k < MAP_W; k++)
            map[k] = (key_state[k] == PHASE_PRESSED);
        if (nev == 0) begin
            tick_reports.push_back('{cur_line, 1'b0, '0, KIND_PRESS, map, 1'b1});
        end else begin
            for (int e = 0; e < nev; e++) begin
                rep = '{cur_line, 1'b1, ev_key[e], ev_kind[e], map, e == nev - 1};
                tick_reports.push_back(rep);
            end
        end
    endfunction

    function automatic t_key_report quiet(input logic [1:0] line, input logic [MAP_W-1:0] map);
        return '{line, 1'b0, '0, KIND_PRESS, map, 1'b1};
    endfunction

    // Item acceptance drives the predictor; accepted results are checked in order.
    always @(posedge i_clk) begin
        t_script_row pin;
        t_key_report want;
        t_key_report got;
        if (i_rst_n) begin
            if (i_valid && !o_stall) begin
                scan_tick(i_return_levels);
                if (pinned_rows.size() != 0) begin
                    pin = pinned_rows.pop_front();
                    if (pin.typed) begin
                        tick_reports.delete();
                        tick_reports.push_back(pin.want);
                    end
                end
                foreach (tick_reports[i]) expected_reports.push_back(tick_reports[i]);
            end
            if (o_valid && !i_stall) begin
                got = '{o_next_scan_line, o_event_valid, o_event_key, o_event_kind,
                        o_pressed_map, o_last_result};
                if (expected_reports.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display({"unexpected result: line=%0d ev=%0b key=%0d kind=%0b",
                                  " map=%05h last=%0b"},
                                 got.next_line, got.has_event, got.key, got.kind, got.map,
                                 got.last);
                end else begin
                    want = expected_reports.pop_front();
                    if (got.next_line !== want.next_line || got.has_event !== want.has_event ||
                        got.key !== want.key || got.kind !== want.kind ||
                        got.map !== want.map || got.last !== want.last) begin
                        mismatches++;
                        if (mismatches <= 10) begin
                            $display("result mismatch at cycle %0d", cycle_count);
                            $display("  exp: line=%0d ev=%0b key=%0d kind=%0b map=%05h last=%0b",
                                     want.next_line, want.has_event, want.key, want.kind,
                                     want.map, want.last);
                            $display("  act: line=%0d ev=%0b key=%0d kind=%0b map=%05h last=%0b",
                                     got.next_line, got.has_event, got.key, got.kind,
                                     got.map, got.last);
                        end
                    end
                end
            end
        end
    end

    // Receiver: stall mode is redrawn at random; long hold-offs on request.
    always @(posedge i_clk) begin
        rx_cycle <= rx_cycle + 1;
        if (rx_cycle % 48 == 0) rx_mode <= $urandom_range(0, 3);
        if (hold_left != 0) begin
            i_stall   <= 1'b1;
            hold_left <= hold_left - 1;
        end else if (holds_served != holds_asked) begin
            holds_served <= holds_served + 1;
            hold_left    <= HOLD_CYCLES - 1;
            i_stall      <= 1'b1;
        end else begin
            case (rx_mode)
                0:       i_stall <= 1'b0;
                1:       i_stall <= ($urandom_range(0, 3) == 0);
                2:       i_stall <= ($urandom_range(0, 2) != 0);
                default: i_stall <= rx_cycle[2];
            endcase
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("== FAIL ==");
            $finish;
        end
    end

    // Offers one item and waits until it is taken; may then open a gap before returning.
    task automatic offer(input logic [LEVELS_W-1:0] lv);
        i_valid         <= 1'b1;
        i_return_levels <= lv;
        do @(posedge i_clk); while (o_stall);
        tx_line = LINE_OUT_W'((int'(tx_line) + 1) % NUM_LINES);
        if (burst_left == 0) begin
            burst_left = $urandom_range(0, 12);
            if (!steady) begin
                i_valid <= 1'b0;
                repeat ($urandom_range(1, 6)) @(posedge i_clk);
            end
        end else begin
            burst_left--;
        end
    endtask

    // Drop valid, wait for every expected result, then let the block go quiet.
    // The first edge lets the checker log the last accepted item.
    task automatic settle();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (expected_reports.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic check_readback();
        psel    <= 1'b1;
        pwrite  <= 1'b0;
        paddr   <= ADDR_LIMIT;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        if (prdata !== {24'b0, flip_limit}) begin
            mismatches++;
            if (mismatches <= 10)
                $display("limit readback: exp %08h act %08h", {24'b0, flip_limit}, prdata);
        end
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic write_limit(input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_LIMIT;
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        flip_limit = (value[LIMIT_W-1:0] == '0) ? 8'd1 : value[LIMIT_W-1:0];
        @(posedge i_clk);
        check_readback();
    endtask

    // Mostly held per-line patterns so keys get past debounce; some bounce and noise.
    function automatic logic [LEVELS_W-1:0] next_levels();
        logic [LEVELS_W-1:0] lv;
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 8)
            held_levels[tx_line] = LEVELS_W'($urandom);
        else if (roll < 13)
            held_levels[tx_line] ^= LEVELS_W'(1 << $urandom_range(0, NUM_RETURNS - 1));
        lv = held_levels[tx_line];
        if ($urandom_range(0, 99) < 10) lv ^= LEVELS_W'(1 << $urandom_range(0, NUM_RETURNS - 1));
        if ($urandom_range(0, 99) < 4) lv = LEVELS_W'($urandom);
        return lv;
    endfunction

    // Raw levels opposite to the debounced state of the line about to be scanned.
    function automatic logic [LEVELS_W-1:0] against_debounced();
        logic [LEVELS_W-1:0] lv;
        for (int r = 0; r < NUM_RETURNS; r++)
            lv[r] = deb_closed[int'(tx_line) * NUM_RETURNS + r];
        return lv;
    endfunction

    task automatic run_random(input int count);
        for (int n = 0; n < count; n++) offer(next_levels());
    endtask

    initial begin
        script = '{
            '{5'h1F, 1'b1, quiet(2'd1, 20'h0)},
            '{5'h1F, 1'b1, quiet(2'd2, 20'h0)},
            '{5'h1F, 1'b1, quiet(2'd3, 20'h0)},
            '{5'h1F, 1'b1, quiet(2'd0, 20'h0)},
            '{5'h00, 1'b1, quiet(2'd1, 20'h0)},
            '{5'h1F, 1'b1, quiet(2'd2, 20'h0)},
            '{5'h1F, 1'b1, quiet(2'd3, 20'h0)},
            '{5'h1F, 1'b1, quiet(2'd0, 20'h0)},
            '{5'h00, 1'b0, '0},                   // five presses in one tick
            '{5'h1E, 1'b1, quiet(2'd2, 20'h1F)},
            '{5'h1F, 1'b1, quiet(2'd3, 20'h1F)},
            '{5'h1F, 1'b1, quiet(2'd0, 20'h1F)},
            '{5'h1F, 1'b1, quiet(2'd1, 20'h1F)},
            '{5'h1E, 1'b0, '0},
            '{5'h1F, 1'b1, quiet(2'd3, 20'h3F)},
            '{5'h1F, 1'b1, quiet(2'd0, 20'h3F)},
            '{5'h1F, 1'b0, '0},                   // five releases
            '{5'h1F, 1'b1, quiet(2'd2, 20'h20)},
            '{5'h0A, 1'b0, '0},
            '{5'h15, 1'b0, '0},
            '{5'h1F, 1'b1, quiet(2'd1, 20'h20)},  // released keys fall back to idle
            '{5'h1F, 1'b0, '0},
            '{5'h1F, 1'b0, '0}
        };

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        check_readback();

        foreach (script[i]) begin
            pinned_rows.push_back(script[i]);
            offer(script[i].levels);
        end
        settle();

        // zero is stored as one
        write_limit(32'h0000_0000);
        run_random(70);
        settle();

        // counts climb at the top limit, then the limit drops beneath them
        write_limit(32'h0000_00FF);
        for (int n = 0; n < 40; n++) offer(against_debounced());
        settle();
        write_limit(32'h0000_0003);
        for (int n = 0; n < 4; n++) offer(against_debounced());

        steady = 1'b1;
        holds_asked++;
        run_random(30);
        steady = 1'b0;
        run_random(30);
        settle();

        write_limit(32'hA5A5_A502);
        run_random(70);
        settle();

        write_limit(32'h0000_0001);
        run_random(50);
        settle();
        repeat (8) @(posedge i_clk);

        if (mismatches == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
